@@ hdl/esf_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package esf_pkg;

	localparam int FRAMES_PER_PACKET_DEF = 9;
	localparam int STATUS_BYTES_DEF      = 3;
	localparam int CHANNEL_BYTES_DEF     = 24;

	localparam int QUEUE_DEPTH = 4;
	localparam int CFG_INDEX_W = 8;

	localparam logic [7:0] SYNC_FIRST    = 8'hBB;
	localparam logic [7:0] SYNC_SECOND   = 8'hAA;
	localparam logic [7:0] TAG_RESET     = 8'd0;
	localparam logic [7:0] BATTERY_RESET = 8'd100;

	localparam logic [CFG_INDEX_W-1:0] REG_TAG     = CFG_INDEX_W'(0);
	localparam logic [CFG_INDEX_W-1:0] REG_BATTERY = CFG_INDEX_W'(1);

	typedef enum logic [2:0] {
		SLOT_SYNC1,
		SLOT_SYNC2,
		SLOT_DATA,
		SLOT_CSUM,
		SLOT_TAG,
		SLOT_BATTERY,
		SLOT_COUNT
	} slot_t;

	typedef struct packed {
		logic [7:0] data;
		logic [7:0] csum;
		logic [7:0] count;
		logic       has_sync;
		logic       has_trailer;
	} entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} queue_status_t;

endpackage
`default_nettype wire

@@ hdl/esf_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
module esf_front #(
	parameter int FRAMES_PER_PACKET = esf_pkg::FRAMES_PER_PACKET_DEF,
	parameter int STATUS_BYTES      = esf_pkg::STATUS_BYTES_DEF,
	parameter int CHANNEL_BYTES     = esf_pkg::CHANNEL_BYTES_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic [7:0]            frame_byte,
	input  wire esf_pkg::queue_status_t q_status,
	output logic                       push,
	output esf_pkg::entry_t            push_entry
);
	import esf_pkg::*;

	localparam int FRAME_LEN = STATUS_BYTES + CHANNEL_BYTES;
	localparam int POS_W     = $clog2(FRAME_LEN);
	localparam int FI_W      = $clog2(FRAMES_PER_PACKET + 1);

	localparam logic [POS_W-1:0] STATUS_POS = POS_W'(STATUS_BYTES);
	localparam logic [POS_W-1:0] LAST_POS   = POS_W'(FRAME_LEN - 1);
	localparam logic [FI_W-1:0]  LAST_FRAME = FI_W'(FRAMES_PER_PACKET - 1);

	logic [POS_W-1:0] pos_q;
	logic [FI_W-1:0]  fi_q;
	logic [7:0]       sum_q;
	logic [7:0]       cnt_q;

	logic       accept;
	logic       is_payload;
	logic       frame_end;
	logic       last_frame;
	logic       closes;
	logic [7:0] sum_next;

	assign in_ready   = !q_status.full;
	assign accept     = in_valid && in_ready;
	assign is_payload = ({1'b0, pos_q} >= {1'b0, STATUS_POS});
	assign frame_end  = (pos_q == LAST_POS);
	assign last_frame = (fi_q == LAST_FRAME);
	assign closes     = frame_end && last_frame;
	assign sum_next   = sum_q + frame_byte;

	assign push                   = accept && is_payload;
	assign push_entry.data        = frame_byte;
	assign push_entry.csum        = ~sum_next;
	assign push_entry.count       = cnt_q + 8'd1;
	assign push_entry.has_sync    = (fi_q == '0) && (pos_q == STATUS_POS);
	assign push_entry.has_trailer = closes;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			fi_q  <= '0;
			sum_q <= '0;
			cnt_q <= '0;
		end else if (accept) begin
			if (is_payload) begin
				sum_q <= sum_next;
			end
			if (frame_end) begin
				pos_q <= '0;
				if (last_frame) begin
					fi_q  <= '0;
					sum_q <= '0;
				end else begin
					fi_q <= fi_q + FI_W'(1);
				end
			end else begin
				pos_q <= pos_q + POS_W'(1);
			end
			if (closes && is_payload) begin
				cnt_q <= cnt_q + 8'd1;
			end
		end
	end

endmodule
`default_nettype wire

@@ hdl/esf_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none
module esf_queue (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  push,
	input  wire esf_pkg::entry_t        push_entry,
	input  wire logic                  pop,
	output esf_pkg::entry_t            head,
	output esf_pkg::queue_status_t     status
);
	import esf_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	entry_t           mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [CNT_W-1:0] cnt_q;

	assign head         = mem_q[rd_q];
	assign status.full  = (cnt_q == CNT_W'(QUEUE_DEPTH));
	assign status.empty = (cnt_q == '0);

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_q <= rd_q + PTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

endmodule
`default_nettype wire

@@ hdl/esf_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
module esf_back (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire esf_pkg::entry_t        head,
	input  wire esf_pkg::queue_status_t q_status,
	output logic                       pop,
	input  wire logic [7:0]            tag_value,
	input  wire logic [7:0]            battery_level,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic [7:0]                 packet_byte,
	output logic                       end_of_packet,
	output logic                       last_of_run
);
	import esf_pkg::*;

	slot_t      step_q;
	logic       started_q;
	logic       out_valid_q;
	logic [7:0] byte_q;
	logic       eop_q;
	logic       last_q;

	slot_t      slot;
	slot_t      last_slot;
	logic       load;
	logic       emit;
	logic       at_last;
	logic [7:0] value;

	always_comb begin
		if (started_q) begin
			slot = step_q;
		end else if (head.has_sync) begin
			slot = SLOT_SYNC1;
		end else begin
			slot = SLOT_DATA;
		end
		last_slot = head.has_trailer ? SLOT_COUNT : SLOT_DATA;
		case (slot)
			SLOT_SYNC1:   value = SYNC_FIRST;
			SLOT_SYNC2:   value = SYNC_SECOND;
			SLOT_DATA:    value = head.data;
			SLOT_CSUM:    value = head.csum;
			SLOT_TAG:     value = tag_value;
			SLOT_BATTERY: value = battery_level;
			SLOT_COUNT:   value = head.count;
			default:      value = head.data;
		endcase
	end

	assign load    = !out_valid_q || out_ready;
	assign emit    = load && !q_status.empty;
	assign at_last = (slot == last_slot);
	assign pop     = emit && at_last;

	assign out_valid     = out_valid_q;
	assign packet_byte   = byte_q;
	assign end_of_packet = eop_q;
	assign last_of_run   = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			started_q   <= 1'b0;
			step_q      <= SLOT_SYNC1;
		end else begin
			if (load) begin
				out_valid_q <= emit;
			end
			if (emit) begin
				if (at_last) begin
					started_q <= 1'b0;
				end else begin
					started_q <= 1'b1;
					step_q    <= slot_t'(slot + 3'd1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			byte_q <= value;
			eop_q  <= (slot == SLOT_COUNT);
			last_q <= at_last;
		end
	end

endmodule
`default_nettype wire

@@ hdl/eeg_sample_packet_framer.sv @@
// Channel   Dir  Handshake               Payload
// in        in   in_valid / in_ready     frame_byte[7:0]
// out       out  out_valid / out_ready   packet_byte[7:0], end_of_packet, last_of_run
// cfg       in   cfg_valid / cfg_ready   cfg_index[7:0], cfg_data[7:0]
//
// One input byte per cycle while the queue has room; status bytes leave no entry.
// The output side emits one byte per cycle while out_ready allows, so a packet
// start expands to 3 output bytes and a packet end to 5; the 4-entry queue absorbs these bursts.
// An accepted byte is written into the queue, then registered at the output before it appears.
// Reset clears counters, sum, queue and output valid; cfg_ready is always high.
`timescale 1ns / 1ps
`default_nettype none
module eeg_sample_packet_framer #(
	parameter int FRAMES_PER_PACKET = esf_pkg::FRAMES_PER_PACKET_DEF,
	parameter int STATUS_BYTES      = esf_pkg::STATUS_BYTES_DEF,
	parameter int CHANNEL_BYTES     = esf_pkg::CHANNEL_BYTES_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	output logic                                 in_ready,
	input  wire logic [7:0]                      frame_byte,
	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output logic [7:0]                           packet_byte,
	output logic                                 end_of_packet,
	output logic                                 last_of_run,
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [esf_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [7:0]                      cfg_data
);
	import esf_pkg::*;

	logic [7:0]    tag_q;
	logic [7:0]    battery_q;
	logic          push;
	logic          pop;
	entry_t        push_entry;
	entry_t        head;
	queue_status_t q_status;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_q     <= TAG_RESET;
			battery_q <= BATTERY_RESET;
		end else if (cfg_valid) begin
			if (cfg_index == REG_TAG) begin
				tag_q <= cfg_data;
			end else if (cfg_index == REG_BATTERY) begin
				battery_q <= cfg_data;
			end
		end
	end

	esf_front #(
		.FRAMES_PER_PACKET(FRAMES_PER_PACKET),
		.STATUS_BYTES     (STATUS_BYTES),
		.CHANNEL_BYTES    (CHANNEL_BYTES)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.frame_byte(frame_byte),
		.q_status  (q_status),
		.push      (push),
		.push_entry(push_entry)
	);

	esf_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_entry(push_entry),
		.pop       (pop),
		.head      (head),
		.status    (q_status)
	);

	esf_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.q_status     (q_status),
		.pop          (pop),
		.tag_value    (tag_q),
		.battery_level(battery_q),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.packet_byte  (packet_byte),
		.end_of_packet(end_of_packet),
		.last_of_run  (last_of_run)
	);

endmodule
`default_nettype wire

@@ verif/packet_stream_checker.sv @@
`timescale 1ns / 1ps
module packet_stream_checker #(
	parameter int FRAMES   = esf_pkg::FRAMES_PER_PACKET_DEF,
	parameter int STATUS   = esf_pkg::STATUS_BYTES_DEF,
	parameter int CHANNELS = esf_pkg::CHANNEL_BYTES_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	input  wire logic                            in_ready,
	input  wire logic [7:0]                      frame_byte,
	input  wire logic                            out_valid,
	input  wire logic                            out_ready,
	input  wire logic [7:0]                      packet_byte,
	input  wire logic                            end_of_packet,
	input  wire logic                            last_of_run,
	input  wire logic                            cfg_valid,
	input  wire logic                            cfg_ready,
	input  wire logic [esf_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [7:0]                      cfg_data,
	output int                                   pending_beats,
	output int                                   mismatch_count
);

	localparam int FRAME_LEN = STATUS + CHANNELS;

	typedef struct packed {
		logic [7:0] value;
		logic       eop;
		logic       last;
	} packet_beat_t;

	packet_beat_t beats_due[$];
	packet_beat_t want;

	logic [4:0] byte_pos;
	logic [3:0] frame_idx;
	logic [7:0] payload_sum;
	logic [7:0] packets_sent;
	logic [7:0] tag_byte;
	logic [7:0] battery_byte;
	int         mismatches = 0;

	assign mismatch_count = mismatches;

	function automatic packet_beat_t make_beat(input logic [7:0] value, input logic eop);
		packet_beat_t beat;
		beat.value = value;
		beat.eop   = eop;
		beat.last  = 1'b0;
		return beat;
	endfunction

	task automatic predict_packet_bytes(input logic [7:0] b);
		packet_beat_t run[8];
		int           n;
		logic         last_frame;
		logic         frame_end;
		n          = 0;
		last_frame = (int'(frame_idx) + 1 >= FRAMES);
		frame_end  = (int'(byte_pos) + 1 >= FRAME_LEN);
		if (int'(byte_pos) >= STATUS) begin
			if (frame_idx == 4'd0 && int'(byte_pos) == STATUS) begin
				run[n] = make_beat(esf_pkg::SYNC_FIRST, 1'b0);
				n++;
				run[n] = make_beat(esf_pkg::SYNC_SECOND, 1'b0);
				n++;
			end
			run[n] = make_beat(b, 1'b0);
			n++;
			payload_sum = payload_sum + b;
			if (frame_end && last_frame) begin
				packets_sent = packets_sent + 8'd1;
				run[n] = make_beat(~payload_sum, 1'b0);
				n++;
				run[n] = make_beat(tag_byte, 1'b0);
				n++;
				run[n] = make_beat(battery_byte, 1'b0);
				n++;
				run[n] = make_beat(packets_sent, 1'b1);
				n++;
			end
		end
		if (frame_end) begin
			byte_pos = 5'd0;
			if (last_frame) begin
				frame_idx   = 4'd0;
				payload_sum = 8'd0;
			end else begin
				frame_idx = frame_idx + 4'd1;
			end
		end else begin
			byte_pos = byte_pos + 5'd1;
		end
		if (n > 0)
			run[n-1].last = 1'b1;
		for (int i = 0; i < n; i++)
			beats_due.push_back(run[i]);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_pos     = 5'd0;
			frame_idx    = 4'd0;
			payload_sum  = 8'd0;
			packets_sent = 8'd0;
			tag_byte     = esf_pkg::TAG_RESET;
			battery_byte = esf_pkg::BATTERY_RESET;
			beats_due.delete();
			pending_beats <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == esf_pkg::REG_TAG)
					tag_byte = cfg_data;
				else if (cfg_index == esf_pkg::REG_BATTERY)
					battery_byte = cfg_data;
			end
			if (out_valid && out_ready) begin
				if (beats_due.size() == 0) begin
					$error("packet_byte: expected nothing, actual %0h", packet_byte);
					mismatches++;
				end else begin
					want = beats_due.pop_front();
					if (packet_byte !== want.value) begin
						$error("packet_byte: expected %0h, actual %0h", want.value, packet_byte);
						mismatches++;
					end
					if (end_of_packet !== want.eop) begin
						$error("end_of_packet: expected %0b, actual %0b", want.eop,
							end_of_packet);
						mismatches++;
					end
					if (last_of_run !== want.last) begin
						$error("last_of_run: expected %0b, actual %0b", want.last, last_of_run);
						mismatches++;
					end
				end
			end
			if (in_valid && in_ready)
				predict_packet_bytes(frame_byte);
			pending_beats <= beats_due.size();
		end
	end

endmodule

@@ verif/tb_eeg_sample_packet_framer.sv @@
`timescale 1ns / 1ps
module tb_eeg_sample_packet_framer;

	localparam int CYCLE_LIMIT   = 300000;
	localparam int SETTLE_CYCLES = 8;
	localparam int LONG_HOLD     = 100;
	localparam int PHASE_ITEMS   = 110;

	logic                            clk        = 1'b0;
	logic                            arst_n     = 1'b0;
	logic                            in_valid   = 1'b0;
	logic [7:0]                      frame_byte = 8'd0;
	logic                            out_ready  = 1'b0;
	logic                            cfg_valid  = 1'b0;
	logic [esf_pkg::CFG_INDEX_W-1:0] cfg_index  = '0;
	logic [7:0]                      cfg_data   = 8'd0;
	logic                            hold_armed = 1'b0;

	wire logic       in_ready;
	wire logic       out_valid;
	wire logic [7:0] packet_byte;
	wire logic       end_of_packet;
	wire logic       last_of_run;
	wire logic       cfg_ready;
	int              pending_beats;
	int              mismatch_count;

	eeg_sample_packet_framer dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.frame_byte    (frame_byte),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.packet_byte   (packet_byte),
		.end_of_packet (end_of_packet),
		.last_of_run   (last_of_run),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	packet_stream_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.frame_byte     (frame_byte),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.packet_byte    (packet_byte),
		.end_of_packet  (end_of_packet),
		.last_of_run    (last_of_run),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.pending_beats  (pending_beats),
		.mismatch_count (mismatch_count)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int idle_len();
		if ($urandom_range(0, 9) == 0)
			return $urandom_range(10, 30);
		return $urandom_range(1, 3);
	endfunction

	function automatic int send_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 30);
	endfunction

	function automatic logic [7:0] pick_byte();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return 8'h00;
		if (r == 1)
			return 8'hFF;
		return 8'($urandom_range(0, 255));
	endfunction

	task automatic send_frame_byte(input logic [7:0] b, input int gap);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid   <= 1'b1;
		frame_byte <= b;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic write_register(input logic [esf_pkg::CFG_INDEX_W-1:0] idx,
		input logic [7:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_beats != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// receiver: random back-pressure in stretches, one long hold when armed
	initial begin : receiver
		int gap_left;
		int calm_left;
		int gap_odds;
		bit hold_done;
		gap_left  = 0;
		calm_left = 0;
		gap_odds  = 0;
		hold_done = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_armed && !hold_done) begin
				hold_done = 1'b1;
				gap_left  = LONG_HOLD;
			end
			if (calm_left == 0) begin
				calm_left = $urandom_range(50, 200);
				gap_odds  = $urandom_range(0, 3);
			end
			calm_left--;
			if (gap_left > 0) begin
				out_ready <= 1'b0;
				gap_left--;
			end else if (gap_odds != 0 && $urandom_range(0, 7) < gap_odds) begin
				out_ready <= 1'b0;
				gap_left = idle_len() - 1;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	initial begin : watchdog
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("eeg_sample_packet_framer: mismatch");
		$finish;
	end

	initial begin : stimulus
		logic [7:0] directed_bytes[20];
		int         burst_left;
		int         gap;
		directed_bytes = '{8'h00, 8'hFF, 8'h80, 8'h00, 8'hFF, 8'h01, 8'h7F, 8'hBB, 8'hAA,
			8'h55, 8'hFE, 8'h80, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'h33, 8'hCC, 8'h0F, 8'hF0};
		burst_left = 0;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// status bytes, packet start with sync, byte extremes
		for (int i = 0; i < 20; i++)
			send_frame_byte(directed_bytes[i], (i % 4 == 3) ? send_gap() : 0);
		settle();

		for (int p = 0; p < 3; p++) begin
			case (p)
				0: begin
					write_register(esf_pkg::REG_TAG, 8'($urandom_range(0, 255)));
					write_register(esf_pkg::REG_BATTERY, 8'($urandom_range(0, 255)));
					write_register('1, 8'hFF);
				end
				1: begin
					write_register(esf_pkg::REG_TAG, 8'h00);
					write_register(esf_pkg::REG_BATTERY, 8'hFF);
					write_register(esf_pkg::CFG_INDEX_W'($urandom_range(2, 254)), 8'h00);
				end
				default: begin
					write_register(esf_pkg::REG_TAG, 8'hFF);
					write_register(esf_pkg::REG_BATTERY, 8'h00);
					write_register(esf_pkg::CFG_INDEX_W'($urandom_range(2, 255)),
						8'($urandom_range(0, 255)));
				end
			endcase
			if (p == 0)
				hold_armed <= 1'b1;
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				if (burst_left > 0) begin
					burst_left--;
					gap = 0;
				end else if ($urandom_range(0, 19) == 0) begin
					burst_left = $urandom_range(10, 40);
					gap = 0;
				end else begin
					gap = send_gap();
				end
				send_frame_byte(pick_byte(), gap);
			end
			settle();
		end

		if (mismatch_count == 0) begin
			$display("eeg_sample_packet_framer: match");
		end else begin
			$display("eeg_sample_packet_framer: mismatch");
		end
		$finish;
	end

endmodule
